// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every clock edge outside reset.
`define BMPR_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that cond implies expr at the same clock edge outside reset.
`define BMPR_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/bmpr_pkg.sv =====
// Types and constants shared by the RLE8 line decoder modules.
package bmpr_pkg;

   localparam int LANES = 4;
   // Pixel fields per beat cap the lanes actually used.
   localparam int LANE_USE = (LANES > 4) ? 4 : ((LANES < 1) ? 1 : LANES);
   localparam int PIX_COUNT_W = 3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam logic LINE_WIDTH_REG = 1'b0;
   localparam logic [15:0] LINE_WIDTH_RESET = 16'd1;

   localparam logic [7:0] ESC_EOL = 8'd0;
   localparam logic [7:0] ESC_EOD = 8'd1;
   localparam logic [7:0] ESC_JUMP = 8'd2;

   typedef enum logic [2:0] {
      ST_DATA      = 3'd0,
      ST_EOL       = 3'd1,
      ST_EOD       = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_JUMP      = 3'd4,
      ST_SHORT     = 3'd5
   } status_type;

   // One command per transaction that yields results; count 0 is status only.
   typedef struct packed {
      logic [7:0] pixel;
      logic [7:0] count;
      status_type status;
   } cmd_type;

endpackage

// ===== rtl/core/bmpr_front.sv =====
// Byte parser: tracks the RLE8 phase and line budget, issues output commands.
module bmpr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        code_byte,
   input  logic              restart,
   input  logic [15:0]       line_width,
   output logic              push,
   output bmpr_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      PH_COUNT  = 5'b00001,
      PH_FILL   = 5'b00010,
      PH_ESCAPE = 5'b00100,
      PH_ABS    = 5'b01000,
      PH_PAD    = 5'b10000
   } phase_type;

   phase_type            phase_ff, phase_in, phase_e;
   logic [15:0]          pixels_left_ff, pixels_left_in, pixels_left_e;
   logic [7:0]           run_left_ff, run_left_in, run_left_e;
   logic                 pad_pending_ff, pad_pending_in, pad_pending_e;
   logic [7:0]           fill_count_ff, fill_count_in, fill_count_e;
   bmpr_pkg::status_type sticky_ff, sticky_in, sticky_e;
   logic                 too_large;

   always_comb begin
      // Restart clears state before this byte is decoded.
      phase_e       = restart ? PH_COUNT : phase_ff;
      pixels_left_e = restart ? line_width : pixels_left_ff;
      run_left_e    = restart ? 8'd0 : run_left_ff;
      pad_pending_e = restart ? 1'b0 : pad_pending_ff;
      fill_count_e  = restart ? 8'd0 : fill_count_ff;
      sticky_e      = restart ? bmpr_pkg::ST_DATA : sticky_ff;

      too_large = {8'h00, code_byte} > pixels_left_e;

      phase_in       = phase_e;
      pixels_left_in = pixels_left_e;
      run_left_in    = run_left_e;
      pad_pending_in = pad_pending_e;
      fill_count_in  = fill_count_e;
      sticky_in      = sticky_e;
      push           = 1'b0;
      cmd.pixel      = code_byte;
      cmd.count      = 8'd0;
      cmd.status     = bmpr_pkg::ST_DATA;

      if (sticky_e != bmpr_pkg::ST_DATA) begin
         push       = 1'b1;
         cmd.status = sticky_e;
      end else begin
         case (phase_e)
            PH_COUNT: begin
               if (code_byte == 8'd0) begin
                  phase_in = PH_ESCAPE;
               end else if (too_large) begin
                  push       = 1'b1;
                  cmd.status = bmpr_pkg::ST_TOO_LARGE;
                  sticky_in  = bmpr_pkg::ST_TOO_LARGE;
               end else begin
                  fill_count_in = code_byte;
                  phase_in      = PH_FILL;
               end
            end
            PH_FILL: begin
               push           = 1'b1;
               cmd.count      = fill_count_e;
               pixels_left_in = pixels_left_e - {8'h00, fill_count_e};
               fill_count_in  = 8'd0;
               phase_in       = PH_COUNT;
            end
            PH_ESCAPE: begin
               push = 1'b1;
               if (code_byte == bmpr_pkg::ESC_JUMP) begin
                  cmd.status = bmpr_pkg::ST_JUMP;
                  sticky_in  = bmpr_pkg::ST_JUMP;
               end else if (code_byte == bmpr_pkg::ESC_EOL ||
                            code_byte == bmpr_pkg::ESC_EOD) begin
                  if (pixels_left_e != 16'd0) begin
                     cmd.status = bmpr_pkg::ST_SHORT;
                     sticky_in  = bmpr_pkg::ST_SHORT;
                  end else if (code_byte == bmpr_pkg::ESC_EOD) begin
                     cmd.status = bmpr_pkg::ST_EOD;
                     sticky_in  = bmpr_pkg::ST_EOD;
                  end else begin
                     cmd.status     = bmpr_pkg::ST_EOL;
                     pixels_left_in = line_width;
                     phase_in       = PH_COUNT;
                  end
               end else if (too_large) begin
                  cmd.status = bmpr_pkg::ST_TOO_LARGE;
                  sticky_in  = bmpr_pkg::ST_TOO_LARGE;
               end else begin
                  // Absolute run header: no result of its own.
                  push           = 1'b0;
                  pixels_left_in = pixels_left_e - {8'h00, code_byte};
                  run_left_in    = code_byte;
                  pad_pending_in = code_byte[0];
                  phase_in       = PH_ABS;
               end
            end
            PH_ABS: begin
               push        = 1'b1;
               cmd.count   = 8'd1;
               run_left_in = run_left_e - 8'd1;
               if (run_left_e == 8'd1) begin
                  phase_in = pad_pending_e ? PH_PAD : PH_COUNT;
               end
            end
            PH_PAD: begin
               pad_pending_in = 1'b0;
               phase_in       = PH_COUNT;
            end
            default: begin
               phase_in = PH_COUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_COUNT;
         pixels_left_ff <= bmpr_pkg::LINE_WIDTH_RESET;
         run_left_ff    <= 8'd0;
         pad_pending_ff <= 1'b0;
         fill_count_ff  <= 8'd0;
         sticky_ff      <= bmpr_pkg::ST_DATA;
      end else if (take) begin
         phase_ff       <= phase_in;
         pixels_left_ff <= pixels_left_in;
         run_left_ff    <= run_left_in;
         pad_pending_ff <= pad_pending_in;
         fill_count_ff  <= fill_count_in;
         sticky_ff      <= sticky_in;
      end
   end

endmodule

// ===== rtl/core/bmpr_cmd_fifo.sv =====
// Short command queue between the byte parser and the beat generator.
module bmpr_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bmpr_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output bmpr_pkg::cmd_type head
);

   bmpr_pkg::cmd_type                   entry_ff [bmpr_pkg::FIFO_DEPTH];
   logic [bmpr_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bmpr_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bmpr_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic                                do_push, do_pop;

   assign full    = count_ff == bmpr_pkg::FIFO_CNT_W'(bmpr_pkg::FIFO_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == bmpr_pkg::FIFO_PTR_W'(bmpr_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == bmpr_pkg::FIFO_PTR_W'(bmpr_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/bmpr_back.sv =====
// Beat generator: expands queued commands into result beats of up to four pixels.
module bmpr_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_empty,
   input  bmpr_pkg::cmd_type                   cmd_head,
   output logic                                cmd_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_pixel_a,
   output logic [7:0]                          rsp_pixel_b,
   output logic [7:0]                          rsp_pixel_c,
   output logic [7:0]                          rsp_pixel_d,
   output logic [bmpr_pkg::PIX_COUNT_W-1:0]    rsp_pixel_count,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_last
);

   localparam logic [7:0] LANE_STEP = 8'(bmpr_pkg::LANE_USE);

   logic              valid_ff, valid_in;
   bmpr_pkg::cmd_type cur_ff, cur_in;
   logic [7:0]        rem_ff, rem_in;
   logic [bmpr_pkg::PIX_COUNT_W-1:0] beat_n;
   logic              beat_done;

   assign beat_n    = (rem_ff > LANE_STEP) ? bmpr_pkg::PIX_COUNT_W'(bmpr_pkg::LANE_USE)
                                           : rem_ff[bmpr_pkg::PIX_COUNT_W-1:0];
   assign rsp_last  = rem_ff <= LANE_STEP;
   assign beat_done = valid_ff && !rsp_stall;
   // Take the next command when idle or when the final beat leaves.
   assign cmd_pop   = !valid_ff || (beat_done && rsp_last);

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_count = beat_n;
   assign rsp_status      = cur_ff.status;
   assign rsp_pixel_a     = (beat_n > 3'd0) ? cur_ff.pixel : 8'd0;
   assign rsp_pixel_b     = (beat_n > 3'd1) ? cur_ff.pixel : 8'd0;
   assign rsp_pixel_c     = (beat_n > 3'd2) ? cur_ff.pixel : 8'd0;
   assign rsp_pixel_d     = (beat_n > 3'd3) ? cur_ff.pixel : 8'd0;

   always_comb begin
      valid_in = valid_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      if (cmd_pop) begin
         valid_in = !cmd_empty;
         cur_in   = cmd_head;
         rem_in   = cmd_head.count;
      end else if (beat_done) begin
         rem_in = rem_ff - LANE_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rem_ff <= rem_in;
   end

endmodule

// ===== rtl/core/bmp_rle8_line_decoder.sv =====
// Top level of the BMP RLE8 line decoder: CSR, parser, command queue, beat output.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_code_byte, req_restart
//   rsp      out        rsp_valid / rsp_stall   rsp_pixel_a..d, rsp_pixel_count,
//                                               rsp_status, rsp_last
//   csr      in/out     psel/penable/pready     paddr, pwdata, prdata (line_width)
//
// The parser takes one byte per cycle while the four-entry command queue has room.
// A fill run leaves as ceil(count/4) beats, one per cycle while rsp_stall is low;
// every other result is one beat, so the output side sets the rate in long fill runs.
// Reset is synchronous and clears all control state; line_width returns to 1.
// req_stall rises only when the command queue is full; rsp_stall holds the beat.
`include "assert_macros.svh"

module bmp_rle8_line_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_code_byte,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_pixel_a,
   output logic [7:0]                          rsp_pixel_b,
   output logic [7:0]                          rsp_pixel_c,
   output logic [7:0]                          rsp_pixel_d,
   output logic [bmpr_pkg::PIX_COUNT_W-1:0]    rsp_pixel_count,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_last,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bmpr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic [15:0]       line_width_ff, line_width_in;
   logic              csr_write;
   logic              take;
   logic              push;
   logic              fifo_full, fifo_empty, fifo_pop;
   bmpr_pkg::cmd_type push_cmd, head_cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // Register index comes from the word address; byte lanes are ignored.
   assign prdata    = (paddr[2] == bmpr_pkg::LINE_WIDTH_REG) ? {16'h0000, line_width_ff}
                                                             : 32'h0000_0000;

   always_comb begin
      line_width_in = line_width_ff;
      if (csr_write && paddr[2] == bmpr_pkg::LINE_WIDTH_REG) begin
         line_width_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= bmpr_pkg::LINE_WIDTH_RESET;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   assign req_stall = fifo_full;
   assign take      = req_valid && !req_stall;

   bmpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .code_byte  (req_code_byte),
      .restart    (req_restart),
      .line_width (line_width_ff),
      .push       (push),
      .cmd        (push_cmd)
   );

   bmpr_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push && take),
      .push_cmd (push_cmd),
      .pop      (fifo_pop),
      .full     (fifo_full),
      .empty    (fifo_empty),
      .head     (head_cmd)
   );

   bmpr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (fifo_empty),
      .cmd_head        (head_cmd),
      .cmd_pop         (fifo_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_a     (rsp_pixel_a),
      .rsp_pixel_b     (rsp_pixel_b),
      .rsp_pixel_c     (rsp_pixel_c),
      .rsp_pixel_d     (rsp_pixel_d),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   // A status-only beat is always final and never carries data status.
   `BMPR_ASSERT_IMPL(a_status_beat, clock, reset, rsp_valid && rsp_pixel_count == 3'd0, rsp_last && rsp_status != bmpr_pkg::ST_DATA)
   // Only the final beat of a transaction may be partly filled.
   `BMPR_ASSERT_IMPL(a_full_beat, clock, reset, rsp_valid && !rsp_last, rsp_pixel_count == 3'(bmpr_pkg::LANE_USE))
   // The parser never issues a command into a full queue.
   `BMPR_ASSERT(a_no_overflow, clock, reset, !(push && take && fifo_full))

endmodule
